[sv/qsl_pkg.sv]
package qsl_pkg;

  // field widths fixed by the channel format
  localparam int KEY_BITS      = 32;
  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // input beat
  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic                       final_key;
  } item_t;

  // output beat
  typedef struct packed {
    logic signed [KEY_BITS-1:0] sorted_key;
    logic                       end_of_run;
    logic                       overflow;
  } result_t;

  // key store address sources
  typedef enum logic [2:0] {
    A_LOAD,
    A_SCAN,
    A_PLACE,
    A_HI,
    A_EMIT,
    A_STK_HI
  } addr_sel_t;

  // key store write data sources
  typedef enum logic [1:0] {
    W_IN,
    W_RD,
    W_TMP,
    W_PIVOT
  } wdata_sel_t;

  // range stack operations
  typedef enum logic [2:0] {
    S_NONE,
    S_INIT,
    S_POP,
    S_PUSH_R,
    S_PUSH_L
  } stk_op_t;

  // scan and place index operations
  typedef enum logic [1:0] {
    I_NONE,
    I_RANGE,
    I_INC_SCAN,
    I_INC_BOTH
  } idx_op_t;

  // output stage operations
  typedef enum logic [1:0] {
    E_NONE,
    E_INIT,
    E_OUT
  } emit_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_LAST,
    C_SP_ZERO,
    C_SCAN_END,
    C_GT_PIVOT,
    C_OUT_BUSY,
    C_EMIT_MORE
  } cond_t;

  typedef logic [4:0] step_t;

  // microprogram step addresses
  localparam step_t ST_LOAD      = 5'd0;
  localparam step_t ST_INIT      = 5'd1;
  localparam step_t ST_POP       = 5'd2;
  localparam step_t ST_RANGE     = 5'd3;
  localparam step_t ST_PIVOT     = 5'd4;
  localparam step_t ST_RD_SCAN   = 5'd5;
  localparam step_t ST_TEST      = 5'd6;
  localparam step_t ST_SW1       = 5'd7;
  localparam step_t ST_SW2       = 5'd8;
  localparam step_t ST_INC       = 5'd9;
  localparam step_t ST_FIN_RD    = 5'd10;
  localparam step_t ST_FIN1      = 5'd11;
  localparam step_t ST_FIN2      = 5'd12;
  localparam step_t ST_PUSH_L    = 5'd13;
  localparam step_t ST_EMIT_INIT = 5'd14;
  localparam step_t ST_EM_RD     = 5'd15;
  localparam step_t ST_EM_OUT    = 5'd16;
  localparam step_t ST_EM_NEXT   = 5'd17;
  localparam step_t ST_DONE      = 5'd18;

  // one control word
  typedef struct packed {
    logic       in_en;
    logic       key_rd;
    addr_sel_t  rd_sel;
    logic       key_wr;
    addr_sel_t  wr_sel;
    wdata_sel_t wsel;
    stk_op_t    stk_op;
    idx_op_t    idx_op;
    logic       pivot_ld;
    logic       tmp_ld;
    emit_op_t   emit_op;
    logic       clr_set;
    cond_t      cond;
    step_t      target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic last_in;
    logic sp_zero;
    logic scan_end;
    logic gt_pivot;
    logic out_busy;
    logic emit_more;
  } flags_t;

  // control store
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '0;
    w.cond = C_NEXT;
    unique case (s)
      // take keys until the final one
      ST_LOAD: begin
        w.in_en  = 1'b1;
        w.wr_sel = A_LOAD;
        w.wsel   = W_IN;
        w.cond   = C_NOT_LAST;
        w.target = ST_LOAD;
      end
      ST_INIT: begin
        w.stk_op = S_INIT;
      end
      ST_POP: begin
        w.stk_op = S_POP;
        w.cond   = C_SP_ZERO;
        w.target = ST_EMIT_INIT;
      end
      ST_RANGE: begin
        w.idx_op = I_RANGE;
        w.key_rd = 1'b1;
        w.rd_sel = A_STK_HI;
      end
      ST_PIVOT: begin
        w.pivot_ld = 1'b1;
      end
      // partition loop
      ST_RD_SCAN: begin
        w.key_rd = 1'b1;
        w.rd_sel = A_SCAN;
        w.cond   = C_SCAN_END;
        w.target = ST_FIN_RD;
      end
      ST_TEST: begin
        w.tmp_ld = 1'b1;
        w.key_rd = 1'b1;
        w.rd_sel = A_PLACE;
        w.cond   = C_GT_PIVOT;
        w.target = ST_INC;
      end
      ST_SW1: begin
        w.key_wr = 1'b1;
        w.wr_sel = A_SCAN;
        w.wsel   = W_RD;
      end
      ST_SW2: begin
        w.key_wr = 1'b1;
        w.wr_sel = A_PLACE;
        w.wsel   = W_TMP;
        w.idx_op = I_INC_BOTH;
        w.cond   = C_ALWAYS;
        w.target = ST_RD_SCAN;
      end
      ST_INC: begin
        w.idx_op = I_INC_SCAN;
        w.cond   = C_ALWAYS;
        w.target = ST_RD_SCAN;
      end
      // pivot into place, then stack the two sides
      ST_FIN_RD: begin
        w.key_rd = 1'b1;
        w.rd_sel = A_PLACE;
      end
      ST_FIN1: begin
        w.key_wr = 1'b1;
        w.wr_sel = A_HI;
        w.wsel   = W_RD;
      end
      ST_FIN2: begin
        w.key_wr = 1'b1;
        w.wr_sel = A_PLACE;
        w.wsel   = W_PIVOT;
        w.stk_op = S_PUSH_R;
      end
      ST_PUSH_L: begin
        w.stk_op = S_PUSH_L;
        w.cond   = C_ALWAYS;
        w.target = ST_POP;
      end
      // stream the sorted store out
      ST_EMIT_INIT: begin
        w.emit_op = E_INIT;
      end
      ST_EM_RD: begin
        w.key_rd = 1'b1;
        w.rd_sel = A_EMIT;
      end
      ST_EM_OUT: begin
        w.emit_op = E_OUT;
        w.cond    = C_OUT_BUSY;
        w.target  = ST_EM_OUT;
      end
      ST_EM_NEXT: begin
        w.cond   = C_EMIT_MORE;
        w.target = ST_EM_RD;
      end
      ST_DONE: begin
        w.clr_set = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = ST_LOAD;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

[sv/qsl_sequencer.sv]
module qsl_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  qsl_pkg::flags_t  flags,
  output qsl_pkg::ctrl_t   ctrl
);

  qsl_pkg::step_t step;
  qsl_pkg::step_t step_next;
  logic           take;

  // control word lookup
  always_comb begin
    ctrl = qsl_pkg::ucode(step);
  end

  // jump condition select
  always_comb begin
    unique case (ctrl.cond)
      qsl_pkg::C_NEXT:      take = 1'b0;
      qsl_pkg::C_ALWAYS:    take = 1'b1;
      qsl_pkg::C_NOT_LAST:  take = ~flags.last_in;
      qsl_pkg::C_SP_ZERO:   take = flags.sp_zero;
      qsl_pkg::C_SCAN_END:  take = flags.scan_end;
      qsl_pkg::C_GT_PIVOT:  take = flags.gt_pivot;
      qsl_pkg::C_OUT_BUSY:  take = flags.out_busy;
      qsl_pkg::C_EMIT_MORE: take = flags.emit_more;
      default:              take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (take) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= qsl_pkg::ST_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

[sv/qsl_datapath.sv]
module qsl_datapath #(
  parameter int DEPTH     = qsl_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = qsl_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  qsl_pkg::ctrl_t    ctrl,
  output qsl_pkg::flags_t   flags,
  input  logic              item_valid,
  input  qsl_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output qsl_pkg::result_t  result
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // key store and range stack
  logic [KEY_WIDTH-1:0] key_mem [DEPTH];
  logic [2*IDX_W-1:0]   stk_mem [DEPTH];

  logic [CNT_W-1:0]     count;
  logic                 dropped;
  logic [CNT_W-1:0]     sp;
  logic [CNT_W-1:0]     emit_idx;
  logic [IDX_W-1:0]     lo;
  logic [IDX_W-1:0]     hi;
  logic [IDX_W-1:0]     scan;
  logic [IDX_W-1:0]     place;
  logic [KEY_WIDTH-1:0] pivot;
  logic [KEY_WIDTH-1:0] tmp;
  logic [KEY_WIDTH-1:0] key_rd;
  logic [2*IDX_W-1:0]   stk_rd;

  logic                 count_full;
  logic                 accept;
  logic                 ld_write;
  logic                 key_we;
  logic [IDX_W-1:0]     key_raddr;
  logic [IDX_W-1:0]     key_waddr;
  logic [KEY_WIDTH-1:0] key_wdata;
  logic                 stk_we;
  logic                 stk_re;
  logic [IDX_W-1:0]     stk_waddr;
  logic [IDX_W-1:0]     stk_raddr;
  logic [2*IDX_W-1:0]   stk_wdata;
  logic                 sp_room;
  logic                 push_r_ok;
  logic                 push_l_ok;
  logic                 out_busy;

  assign count_full = (count == CNT_W'(DEPTH));
  assign accept     = ctrl.in_en & item_valid;
  assign ld_write   = accept & ~count_full;
  assign key_we     = ctrl.key_wr | ld_write;
  assign sp_room    = (sp < CNT_W'(DEPTH));
  assign push_r_ok  = (({1'b0, place} + (IDX_W+1)'(1)) < {1'b0, hi}) & sp_room;
  assign push_l_ok  = ({1'b0, place} > ({1'b0, lo} + (IDX_W+1)'(1))) & sp_room;
  assign out_busy   = result_valid & result_stall;

  // key store read address
  always_comb begin
    case (ctrl.rd_sel)
      qsl_pkg::A_SCAN:   key_raddr = scan;
      qsl_pkg::A_PLACE:  key_raddr = place;
      qsl_pkg::A_HI:     key_raddr = hi;
      qsl_pkg::A_EMIT:   key_raddr = emit_idx[IDX_W-1:0];
      qsl_pkg::A_STK_HI: key_raddr = stk_rd[IDX_W-1:0];
      default:           key_raddr = count[IDX_W-1:0];
    endcase
  end

  // key store write address
  always_comb begin
    case (ctrl.wr_sel)
      qsl_pkg::A_SCAN:   key_waddr = scan;
      qsl_pkg::A_PLACE:  key_waddr = place;
      qsl_pkg::A_HI:     key_waddr = hi;
      qsl_pkg::A_EMIT:   key_waddr = emit_idx[IDX_W-1:0];
      qsl_pkg::A_STK_HI: key_waddr = stk_rd[IDX_W-1:0];
      default:           key_waddr = count[IDX_W-1:0];
    endcase
  end

  // key store write data
  always_comb begin
    case (ctrl.wsel)
      qsl_pkg::W_RD:    key_wdata = key_rd;
      qsl_pkg::W_TMP:   key_wdata = tmp;
      qsl_pkg::W_PIVOT: key_wdata = pivot;
      default:          key_wdata = KEY_WIDTH'(item.key);
    endcase
  end

  // range stack port control
  always_comb begin
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = sp[IDX_W-1:0];
    stk_raddr = IDX_W'(sp - CNT_W'(1));
    stk_wdata = {lo, IDX_W'(place - IDX_W'(1))};
    case (ctrl.stk_op)
      qsl_pkg::S_INIT: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = {IDX_W'(0), IDX_W'(count - CNT_W'(1))};
      end
      qsl_pkg::S_POP: begin
        stk_re = (sp != '0);
      end
      qsl_pkg::S_PUSH_R: begin
        stk_we    = push_r_ok;
        stk_wdata = {IDX_W'(place + IDX_W'(1)), hi};
      end
      qsl_pkg::S_PUSH_L: begin
        stk_we = push_l_ok;
      end
      default: begin
        stk_we = 1'b0;
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (ctrl.key_rd) begin
      key_rd <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd <= stk_mem[stk_raddr];
    end
  end

  // fill count, drop flag, stack pointer, emit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      sp       <= '0;
      emit_idx <= '0;
    end else begin
      if (accept) begin
        if (count_full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (ctrl.clr_set) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      case (ctrl.stk_op)
        qsl_pkg::S_INIT: begin
          sp <= (count > CNT_W'(1)) ? CNT_W'(1) : '0;
        end
        qsl_pkg::S_POP: begin
          if (sp != '0) begin
            sp <= sp - CNT_W'(1);
          end
        end
        qsl_pkg::S_PUSH_R: begin
          if (push_r_ok) begin
            sp <= sp + CNT_W'(1);
          end
        end
        qsl_pkg::S_PUSH_L: begin
          if (push_l_ok) begin
            sp <= sp + CNT_W'(1);
          end
        end
        default: begin
          sp <= sp;
        end
      endcase
      if (ctrl.emit_op == qsl_pkg::E_INIT) begin
        emit_idx <= '0;
      end else if (ctrl.emit_op == qsl_pkg::E_OUT && !out_busy) begin
        emit_idx <= emit_idx + CNT_W'(1);
      end
    end
  end

  // partition indices and holding registers
  always_ff @(posedge clk) begin
    case (ctrl.idx_op)
      qsl_pkg::I_RANGE: begin
        lo    <= stk_rd[2*IDX_W-1:IDX_W];
        hi    <= stk_rd[IDX_W-1:0];
        scan  <= stk_rd[2*IDX_W-1:IDX_W];
        place <= stk_rd[2*IDX_W-1:IDX_W];
      end
      qsl_pkg::I_INC_SCAN: begin
        scan <= scan + IDX_W'(1);
      end
      qsl_pkg::I_INC_BOTH: begin
        scan  <= scan + IDX_W'(1);
        place <= place + IDX_W'(1);
      end
      default: begin
        scan <= scan;
      end
    endcase
    if (ctrl.pivot_ld) begin
      pivot <= key_rd;
    end
    if (ctrl.tmp_ld) begin
      tmp <= key_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.emit_op == qsl_pkg::E_OUT && !out_busy) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_op == qsl_pkg::E_OUT && !out_busy) begin
      result.sorted_key <= qsl_pkg::KEY_BITS'(key_rd);
      result.end_of_run <= ((emit_idx + CNT_W'(1)) == count);
      result.overflow   <= dropped;
    end
  end

  // status to the sequencer
  always_comb begin
    flags.last_in   = accept & item.final_key;
    flags.sp_zero   = (sp == '0);
    flags.scan_end  = (scan == hi);
    flags.gt_pivot  = ($signed(key_rd) > $signed(pivot));
    flags.out_busy  = out_busy;
    flags.emit_more = (emit_idx != count);
  end

endmodule

[sv/quicksort_lomuto.sv]
// Quicksort with Lomuto partition, microcoded. Keys arrive one beat per cycle
// into a store of DEPTH entries; the beat with final_key set closes the set and
// keys offered to a full store are dropped and flagged on every output beat.
// The set is then sorted in place (last element as pivot, keys <= pivot to the
// left, an explicit range stack instead of recursion) and streamed out in
// ascending order with end_of_run on the greatest key. The control store steps a
// datapath with one read and one write port on the key store. A partition compare
// reads the scan key and tests it against the pivot; a key that stays is skipped,
// one that is swapped trades places with the key at the place index. Every
// partitioned range adds steps for pop, pivot fetch, final swap and pushes;
// emitting reads, outputs and advances per key and waits out output stalls. Keys
// are not accepted during sort or emit.
module quicksort_lomuto #(
  parameter int DEPTH     = qsl_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = qsl_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  qsl_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output qsl_pkg::result_t  result
);

  qsl_pkg::ctrl_t  ctrl;
  qsl_pkg::flags_t flags;

  // control store and step counter
  qsl_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // store, stack, indices and output register
  qsl_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .flags        (flags),
    .item_valid   (item_valid),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // input beats only while loading
  assign item_stall = ~ctrl.in_en;

  // a new output beat only comes from an emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ctrl.emit_op == qsl_pkg::E_OUT))
    else $error("output beat without emit step");

  // the final key closes the set at once
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.final_key) |=> item_stall)
    else $error("input still open after final key");

  // a stalled output beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled output beat changed");

endmodule

[verif/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  // expected sorted beats, built from the keys the block has taken
  class sort_scoreboard;
    logic signed [qsl_pkg::KEY_BITS-1:0] held_keys[$];
    qsl_pkg::result_t                    sorted_beats[$];
    bit                                  dropped;
    int                                  mismatches;
    int                                  keys_offered;
    int                                  beats_checked;
    int                                  sets_closed;
    int                                  overflow_sets;

    // ascending order, signed compare
    function void sort_held();
      logic signed [qsl_pkg::KEY_BITS-1:0] v;
      int j;
      for (int i = 1; i < held_keys.size(); i++) begin
        v = held_keys[i];
        j = i;
        while (j > 0 && held_keys[j-1] > v) begin
          held_keys[j] = held_keys[j-1];
          j--;
        end
        held_keys[j] = v;
      end
    endfunction

    // one accepted input beat; a final key closes the set
    function void take_key(logic signed [qsl_pkg::KEY_BITS-1:0] k, logic fin);
      qsl_pkg::result_t beat;
      keys_offered++;
      if (held_keys.size() < qsl_pkg::DEPTH_DEF) held_keys.push_back(k);
      else dropped = 1'b1;
      if (fin) begin
        sort_held();
        foreach (held_keys[i]) begin
          beat.sorted_key = held_keys[i];
          beat.end_of_run = (i == held_keys.size() - 1);
          beat.overflow   = dropped;
          sorted_beats.push_back(beat);
        end
        sets_closed++;
        if (dropped) overflow_sets++;
        held_keys.delete();
        dropped = 1'b0;
      end
    endfunction

    // one accepted output beat against the oldest expectation
    function void check_beat(qsl_pkg::result_t got);
      qsl_pkg::result_t want;
      beats_checked++;
      if (sorted_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: key %0d end %0b ovf %0b",
                   got.sorted_key, got.end_of_run, got.overflow);
        return;
      end
      want = sorted_beats.pop_front();
      if (got.sorted_key !== want.sorted_key || got.end_of_run !== want.end_of_run ||
          got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: expected key %0d end %0b ovf %0b, got key %0d end %0b ovf %0b",
                   beats_checked, want.sorted_key, want.end_of_run, want.overflow,
                   got.sorted_key, got.end_of_run, got.overflow);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  qsl_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  qsl_pkg::result_t result;

  sort_scoreboard sb = new();
  bit  calm = 1'b0;
  int  stall_left = 0;
  int  cycles = 0;
  int  random_keys = 0;
  logic signed [qsl_pkg::KEY_BITS-1:0] set_keys[$];

  quicksort_lomuto DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output side: random stall bursts, none in the calm tail
  always @(negedge clk) begin
    if (calm) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_beat(result);
  end

  // one key beat; called and returns at a falling edge
  task automatic send_key(logic signed [qsl_pkg::KEY_BITS-1:0] k, logic fin);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid     <= 1'b1;
    item.key       <= k;
    item.final_key <= fin;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.take_key(k, fin);
    @(negedge clk);
  endtask

  // send set_keys, final flag on the last one
  task automatic play_set();
    foreach (set_keys[i]) send_key(set_keys[i], i == set_keys.size() - 1);
  endtask

  // mostly full-range keys, some narrow ones for duplicates, some extremes
  function automatic logic signed [qsl_pkg::KEY_BITS-1:0] pick_key();
    int style;
    style = $urandom_range(0, 9);
    if (style <= 5) return $urandom;
    if (style <= 8) return $signed($urandom_range(0, 15)) - 8;
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic random_set(int n);
    set_keys.delete();
    repeat (n) set_keys.push_back(pick_key());
    play_set();
    random_keys += n;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: lone extremes, a pair, duplicates, presorted, reversed, all equal
    set_keys = '{32'sh8000_0000};
    play_set();
    set_keys = '{32'sh7fff_ffff};
    play_set();
    set_keys = '{32'sh7fff_ffff, 32'sh8000_0000};
    play_set();
    set_keys = '{0, -1, 1, 0, -1};
    play_set();
    set_keys = '{-2, -1, 0, 1, 2};
    play_set();
    set_keys = '{32'sh7fff_ffff, 1000, 0, -1, -1000, 32'sh8000_0000};
    play_set();
    set_keys = '{32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555};
    play_set();

    // random sets of small size
    while (random_keys < 24) random_set($urandom_range(1, 12));

    // a store filled exactly
    random_set(qsl_pkg::DEPTH_DEF);

    // tail with no idling on either side: an overflowed store, then a short set
    calm = 1'b1;
    random_set($urandom_range(qsl_pkg::DEPTH_DEF + 1, qsl_pkg::DEPTH_DEF + 2));
    random_set($urandom_range(1, 6));
    item_valid <= 1'b0;

    while (sb.sorted_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d sets closed (%0d with dropped keys), %0d keys offered, %0d beats checked",
             sb.sets_closed, sb.overflow_sets, sb.keys_offered, sb.beats_checked);
    $display("%0d mismatches, %0d beats still expected", sb.mismatches,
             sb.sorted_beats.size());
    if (sb.mismatches == 0 && sb.sorted_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
